// ===== rtl/core/nnrl_pkg.sv =====
// shared types and constants for the nearest neighbor resizer with letterboxing
// no dependencies
`default_nettype none
package nnrl_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int DIM_W = 9;
  localparam int VW_W  = 19;
  localparam int NUM_W = 29;
  localparam int DEN_W = 10;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_H = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP  = 3'd4;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EMIT  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [15:0] write_index;
    logic [7:0]  write_value;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic [7:0] out_column;
    logic [7:0] out_row;
    logic       frame_last;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_SDIV,
    S_SAPPLY,
    S_XGO,
    S_XDIV,
    S_YGO,
    S_YDIV,
    S_ADDR,
    S_READ,
    S_DATA
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/nnrl_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none
module nnrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/nnrl_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on nnrl_pkg
`default_nettype none
module nnrl_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [nnrl_pkg::NUM_W-1:0] numer,
  input  wire logic [nnrl_pkg::DEN_W-1:0] denom,
  output logic                          busy,
  output logic                          done,
  output logic      [nnrl_pkg::NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(nnrl_pkg::NUM_W);

  logic                         busy_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [nnrl_pkg::NUM_W-1:0]   num_r;
  logic [nnrl_pkg::DEN_W-1:0]   rem_r;
  logic [nnrl_pkg::DEN_W-1:0]   den_r;
  logic [nnrl_pkg::DEN_W:0]     trial;
  logic                         qbit;
  logic [nnrl_pkg::DEN_W-1:0]   rem_nxt;

  always_comb begin
    trial = {rem_r, num_r[nnrl_pkg::NUM_W-1]};
    qbit  = (trial >= {1'b0, den_r});
    if (qbit) begin
      rem_nxt = nnrl_pkg::DEN_W'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[nnrl_pkg::DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(nnrl_pkg::NUM_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= numer;
      den_r <= denom;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[nnrl_pkg::NUM_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = busy_r && (cnt_r == CNT_W'(nnrl_pkg::NUM_W - 1));
  assign quot = num_r;

endmodule
`default_nettype wire

// ===== rtl/core/nearest_neighbour_resize_letterbox_top.sv =====
// nearest neighbor resizer with optional letterboxing, top level
// depends on nnrl_pkg, nnrl_div and nnrl_ram
//
// A write item stores one grey pixel in the frame store.
// An emit item produces the next output pixel in raster order. It runs two
// divisions through one shared 29-step serial divider (column, then row), a
// mapping state, a frame store read and a result state that loads the output
// register once it is free. The first pixel of a frame passes through a
// setup state first, and when keep_aspect is set and the two scale ratios
// differ by more than 2%, a setup division and an apply state follow. Sizes and
// keep_aspect are latched at the first pixel of each frame. The finished
// result sits in an output register, so writes are taken while it waits.
`default_nettype none
module nearest_neighbour_resize_letterbox_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire nnrl_pkg::in_t                      in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output nnrl_pkg::out_t                          out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [nnrl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [nnrl_pkg::DIM_W-1:0]         cfg_data
);

  localparam int DEPTH = nnrl_pkg::MAX_WIDTH * nnrl_pkg::MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = nnrl_pkg::DIM_W;
  localparam int VW    = nnrl_pkg::VW_W;

  nnrl_pkg::state_t state_r, state_nxt;

  logic [DW-1:0] cfg_sw_r, cfg_sh_r, cfg_tw_r, cfg_th_r;
  logic          cfg_keep_r;
  logic [DW-1:0] sw_r, sh_r, tw_r, th_r;
  logic          keep_r;
  logic [DW-1:0] col_r, row_r;
  logic [VW-1:0] vw_r, vh_r, off_r;
  logic          pad_cols_r;
  logic          wide_r;
  logic [VW-1:0] vx_r;
  logic          pad_r;
  logic [DW-1:0] sx_r, sy_r;
  logic          out_valid_r;
  nnrl_pkg::out_t out_r;

  logic          in_acc, emit_acc, wr_acc;
  logic          div_start, div_busy, div_done;
  logic [nnrl_pkg::NUM_W-1:0] div_num, quot;
  logic [nnrl_pkg::DEN_W-1:0] div_den;
  logic          ram_re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic          out_free;

  logic [17:0]   a_prod, b_prod, lo, hi;
  logic          aspect_off;
  logic [VW-1:0] vy_w, sxw, syw, nq;
  logic          pad_w;
  logic          col_end, last_w;

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v, input int maxv);
    logic [DW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DW'(1);
    end else if (32'(v) > maxv) begin
      r = DW'(maxv);
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign emit_acc  = in_acc && (in_data.command == nnrl_pkg::CMD_EMIT);
  assign wr_acc    = in_acc && (in_data.command == nnrl_pkg::CMD_WRITE);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    a_prod     = 18'(tw_r) * 18'(sh_r);
    b_prod     = 18'(th_r) * 18'(sw_r);
    lo         = (a_prod < b_prod) ? a_prod : b_prod;
    hi         = (a_prod < b_prod) ? b_prod : a_prod;
    aspect_off = keep_r && (24'(lo) * 24'd50 < 24'(hi) * 24'd49);
    nq         = quot[VW-1:0];
    vy_w       = quot[VW-1:0];
    sxw        = vx_r;
    syw        = vy_w;
    pad_w      = 1'b0;
    if (pad_cols_r) begin
      if (vx_r < off_r) pad_w = 1'b1;
      else sxw = vx_r - off_r;
    end else begin
      if (vy_w < off_r) pad_w = 1'b1;
      else syw = vy_w - off_r;
    end
    if (sxw >= VW'(sw_r) || syw >= VW'(sh_r)) pad_w = 1'b1;
    col_end = (10'(col_r) + 10'd1 >= 10'(tw_r));
    last_w  = col_end && (10'(row_r) + 10'd1 >= 10'(th_r));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nnrl_pkg::S_IDLE: begin
        if (emit_acc) begin
          if (col_r == '0 && row_r == '0) state_nxt = nnrl_pkg::S_SETUP;
          else state_nxt = nnrl_pkg::S_XGO;
        end
      end
      nnrl_pkg::S_SETUP: begin
        if (aspect_off) state_nxt = nnrl_pkg::S_SDIV;
        else state_nxt = nnrl_pkg::S_XGO;
      end
      nnrl_pkg::S_SDIV:   if (div_done) state_nxt = nnrl_pkg::S_SAPPLY;
      nnrl_pkg::S_SAPPLY: state_nxt = nnrl_pkg::S_XGO;
      nnrl_pkg::S_XGO:    state_nxt = nnrl_pkg::S_XDIV;
      nnrl_pkg::S_XDIV:   if (div_done) state_nxt = nnrl_pkg::S_YGO;
      nnrl_pkg::S_YGO:    state_nxt = nnrl_pkg::S_YDIV;
      nnrl_pkg::S_YDIV:   if (div_done) state_nxt = nnrl_pkg::S_ADDR;
      nnrl_pkg::S_ADDR:   state_nxt = nnrl_pkg::S_READ;
      nnrl_pkg::S_READ:   state_nxt = nnrl_pkg::S_DATA;
      nnrl_pkg::S_DATA:   if (out_free) state_nxt = nnrl_pkg::S_IDLE;
      default:            state_nxt = nnrl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == nnrl_pkg::S_IDLE);
    ram_re    = (state_r == nnrl_pkg::S_READ);
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      nnrl_pkg::S_SETUP: begin
        div_start = aspect_off;
        if (a_prod > b_prod) begin
          div_num = nnrl_pkg::NUM_W'({a_prod, 1'b0} + 19'(th_r));
          div_den = {th_r, 1'b0};
        end else begin
          div_num = nnrl_pkg::NUM_W'({b_prod, 1'b0} + 19'(tw_r));
          div_den = {tw_r, 1'b0};
        end
      end
      nnrl_pkg::S_XGO: begin
        div_start = 1'b1;
        div_num   = nnrl_pkg::NUM_W'({col_r, 1'b1}) * nnrl_pkg::NUM_W'(vw_r);
        div_den   = {tw_r, 1'b0};
      end
      nnrl_pkg::S_YGO: begin
        div_start = 1'b1;
        div_num   = nnrl_pkg::NUM_W'({row_r, 1'b1}) * nnrl_pkg::NUM_W'(vh_r);
        div_den   = {th_r, 1'b0};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign raddr = AW'(18'(sy_r) * 18'(sw_r) + 18'(sx_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nnrl_pkg::S_IDLE;
      cfg_sw_r    <= DW'(256);
      cfg_sh_r    <= DW'(256);
      cfg_tw_r    <= DW'(256);
      cfg_th_r    <= DW'(256);
      cfg_keep_r  <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      pad_cols_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nnrl_pkg::REG_SRC_W: cfg_sw_r   <= cfg_data;
          nnrl_pkg::REG_SRC_H: cfg_sh_r   <= cfg_data;
          nnrl_pkg::REG_TGT_W: cfg_tw_r   <= cfg_data;
          nnrl_pkg::REG_TGT_H: cfg_th_r   <= cfg_data;
          nnrl_pkg::REG_KEEP:  cfg_keep_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (state_r == nnrl_pkg::S_IDLE && emit_acc && col_r == '0 && row_r == '0) begin
        pad_cols_r <= 1'b0;
      end
      if (state_r == nnrl_pkg::S_SAPPLY && wide_r && nq > VW'(sw_r)) begin
        pad_cols_r <= 1'b1;
      end
      if (out_ready) out_valid_r <= 1'b0;
      if (state_r == nnrl_pkg::S_DATA && out_free) begin
        out_valid_r <= 1'b1;
        if (col_end) begin
          col_r <= '0;
          row_r <= last_w ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == nnrl_pkg::S_IDLE && emit_acc && col_r == '0 && row_r == '0) begin
      sw_r   <= clamp_dim(cfg_sw_r, nnrl_pkg::MAX_WIDTH);
      sh_r   <= clamp_dim(cfg_sh_r, nnrl_pkg::MAX_HEIGHT);
      tw_r   <= clamp_dim(cfg_tw_r, nnrl_pkg::MAX_WIDTH);
      th_r   <= clamp_dim(cfg_th_r, nnrl_pkg::MAX_HEIGHT);
      keep_r <= cfg_keep_r;
      vw_r   <= VW'(clamp_dim(cfg_sw_r, nnrl_pkg::MAX_WIDTH));
      vh_r   <= VW'(clamp_dim(cfg_sh_r, nnrl_pkg::MAX_HEIGHT));
      off_r  <= '0;
    end
    if (state_r == nnrl_pkg::S_SETUP) begin
      wide_r <= (a_prod > b_prod);
    end
    if (state_r == nnrl_pkg::S_SAPPLY) begin
      if (wide_r) begin
        if (nq > VW'(sw_r)) begin
          vw_r  <= nq;
          off_r <= (nq - VW'(sw_r)) >> 1;
        end
      end else if (nq > VW'(sh_r)) begin
        vh_r  <= nq;
        off_r <= (nq - VW'(sh_r)) >> 1;
      end
    end
    if (state_r == nnrl_pkg::S_YGO) begin
      vx_r <= quot[VW-1:0];
    end
    if (state_r == nnrl_pkg::S_ADDR) begin
      pad_r <= pad_w;
      sx_r  <= sxw[DW-1:0];
      sy_r  <= syw[DW-1:0];
    end
    if (state_r == nnrl_pkg::S_DATA && out_free) begin
      out_r.pixel_value <= pad_r ? 8'd0 : rdata;
      out_r.out_column  <= col_r[7:0];
      out_r.out_row     <= row_r[7:0];
      out_r.frame_last  <= last_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  nnrl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (div_num),
    .denom (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  nnrl_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_acc && (32'(in_data.write_index) < DEPTH)),
    .waddr (AW'(in_data.write_index)),
    .wdata (in_data.write_value),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.frame_last |-> col_r == '0 && row_r == '0)
    else $error("counters not cleared after last pixel");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> state_r == nnrl_pkg::S_SDIV || state_r == nnrl_pkg::S_XDIV ||
                 state_r == nnrl_pkg::S_YDIV)
    else $error("divider busy outside a divide state");

  a_pad_cols: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nnrl_pkg::S_ADDR && pad_cols_r |-> vh_r == VW'(sh_r))
    else $error("column padding with stretched height");

endmodule
`default_nettype wire

// ===== verif/nearest_neighbour_resize_letterbox_top_tb.sv =====
// testbench for the nearest neighbor resizer with letterboxing
// depends on nnrl_pkg and the rtl under rtl/core; self-checking against an internal predictor
`timescale 1ns / 1ps
module nearest_neighbour_resize_letterbox_top_tb;

  localparam int STORE_DEPTH = 65536;
  localparam int DIM_MAX = 256;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  nnrl_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  nnrl_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [nnrl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [nnrl_pkg::DIM_W-1:0] cfg_data = '0;

  nearest_neighbour_resize_letterbox_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // resizer state mirror
  logic [7:0] pixel_mem [STORE_DEPTH];
  bit written [STORE_DEPTH];
  int reg_sw = 256, reg_sh = 256, reg_tw = 256, reg_th = 256, reg_keep = 0;
  int lat_sw, lat_sh, lat_tw, lat_th;
  int virt_w, virt_h, pad_off, pad_cols;
  int col_cnt = 0, row_cnt = 0;
  nnrl_pkg::out_t pending_pixels[$];
  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  function automatic int clamp_dim(int v);
    if (v < 1) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  function automatic void latch_frame();
    longint a, b, lo, hi, nw, nh;
    lat_sw = clamp_dim(reg_sw);
    lat_sh = clamp_dim(reg_sh);
    lat_tw = clamp_dim(reg_tw);
    lat_th = clamp_dim(reg_th);
    virt_w = lat_sw;
    virt_h = lat_sh;
    pad_off = 0;
    pad_cols = 0;
    if (reg_keep == 0) return;
    a = longint'(lat_tw) * lat_sh;
    b = longint'(lat_th) * lat_sw;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (50 * lo >= 49 * hi) return;
    if (a > b) begin
      nw = (2 * a + lat_th) / (2 * lat_th);
      if (nw > lat_sw) begin
        virt_w = int'(nw);
        pad_off = int'((nw - lat_sw) / 2);
        pad_cols = 1;
      end
    end else begin
      nh = (2 * b + lat_tw) / (2 * lat_tw);
      if (nh > lat_sh) begin
        virt_h = int'(nh);
        pad_off = int'((nh - lat_sh) / 2);
      end
    end
  endfunction

  // source address of the next output pixel, -1 in padding
  function automatic int next_source_addr();
    longint vx, vy, sx, sy;
    if (col_cnt == 0 && row_cnt == 0) latch_frame();
    vx = ((2 * longint'(col_cnt) + 1) * virt_w) / (2 * longint'(lat_tw));
    vy = ((2 * longint'(row_cnt) + 1) * virt_h) / (2 * longint'(lat_th));
    sx = vx;
    sy = vy;
    if (pad_cols != 0) begin
      if (vx < pad_off) return -1;
      sx = vx - pad_off;
    end else begin
      if (vy < pad_off) return -1;
      sy = vy - pad_off;
    end
    if (sx >= lat_sw || sy >= lat_sh) return -1;
    return int'(sy * lat_sw + sx);
  endfunction

  function automatic void predict_pixel();
    nnrl_pkg::out_t r;
    int addr;
    bit last;
    addr = next_source_addr();
    last = (col_cnt + 1 >= lat_tw) && (row_cnt + 1 >= lat_th);
    r.pixel_value = (addr < 0) ? 8'd0 : pixel_mem[addr];
    r.out_column = col_cnt[7:0];
    r.out_row = row_cnt[7:0];
    r.frame_last = last;
    pending_pixels.push_back(r);
    if (col_cnt + 1 >= lat_tw) begin
      col_cnt = 0;
      row_cnt = last ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
  endfunction

  // leaves in_valid high after the transfer; caller ends with stop_input
  task automatic send_item(input nnrl_pkg::in_t item);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (item.command == nnrl_pkg::CMD_WRITE) begin
      pixel_mem[item.write_index] = item.write_value;
      written[item.write_index] = 1'b1;
    end else begin
      predict_pixel();
    end
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  task automatic write_pixel(input int idx, input int val);
    nnrl_pkg::in_t it;
    it.command = nnrl_pkg::CMD_WRITE;
    it.write_index = idx[15:0];
    it.write_value = val[7:0];
    send_item(it);
  endtask

  // emit one pixel, storing its source entry first if it was never written
  task automatic emit_pixel();
    nnrl_pkg::in_t it;
    int addr;
    addr = next_source_addr();
    if (addr >= 0 && !written[addr]) write_pixel(addr, $urandom_range(0, 255));
    it.command = nnrl_pkg::CMD_EMIT;
    it.write_index = $urandom_range(0, 65535);
    it.write_value = $urandom_range(0, 255);
    send_item(it);
  endtask

  task automatic emit_frame(input int write_mix);
    do begin
      if ($urandom_range(0, 99) < write_mix) begin
        write_pixel($urandom_range(0, 65535), $urandom_range(0, 255));
      end
      emit_pixel();
    end while (col_cnt != 0 || row_cnt != 0);
    stop_input();
  endtask

  task automatic set_sizes(input int sw, input int sh, input int tw, input int th,
                           input int keep);
    int vals[5];
    logic [nnrl_pkg::CFG_IDX_W-1:0] idx[5];
    vals = '{sw, sh, tw, th, keep};
    idx = '{nnrl_pkg::REG_SRC_W, nnrl_pkg::REG_SRC_H, nnrl_pkg::REG_TGT_W,
            nnrl_pkg::REG_TGT_H, nnrl_pkg::REG_KEEP};
    stop_input();
    wait (pending_pixels.size() == 0);
    repeat (120) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i][nnrl_pkg::DIM_W-1:0];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    reg_sw = vals[0] & 9'h1ff;
    reg_sh = vals[1] & 9'h1ff;
    reg_tw = vals[2] & 9'h1ff;
    reg_th = vals[3] & 9'h1ff;
    reg_keep = vals[4] & 1;
  endtask

  task automatic test_same_size();
    set_sizes(2, 2, 2, 2, 0);
    for (int i = 0; i < 4; i++) write_pixel(i, (i == 0) ? 0 : (i == 3) ? 255 : 8'h5a + i);
    emit_frame(0);
  endtask

  task automatic test_letterbox();
    set_sizes(4, 4, 8, 2, 1);
    emit_frame(0);
    set_sizes(4, 4, 2, 8, 1);
    emit_frame(0);
  endtask

  task automatic test_size_clamp();
    set_sizes(0, 511, 511, 0, 1);
    emit_frame(0);
    set_sizes(256, 256, 1, 256, 1);
    emit_frame(0);
    set_sizes(300, 1, 9, 1, 0);
    emit_frame(0);
  endtask

  function automatic int pick_source();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(257, 511);
    if (r < 8) return $urandom_range(1, 256);
    return $urandom_range(1, 12);
  endfunction

  task automatic test_random_frames();
    while (items_sent < 950) begin
      set_sizes(pick_source(), pick_source(), $urandom_range(0, 10), $urandom_range(1, 10),
                $urandom_range(0, 1));
      emit_frame($urandom_range(0, 40));
    end
  endtask

  // result receiver stall pattern
  always @(posedge clk) begin
    case ((idle_cycles + items_sent / 64) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 9) < 2);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel transfer col=%0d row=%0d", out_data.out_column,
               out_data.out_row);
        errors++;
      end else begin
        nnrl_pkg::out_t e;
        e = pending_pixels.pop_front();
        if (out_data.pixel_value !== e.pixel_value) begin
          $error("pixel_value expected %0d actual %0d", e.pixel_value, out_data.pixel_value);
          errors++;
        end
        if (out_data.out_column !== e.out_column) begin
          $error("out_column expected %0d actual %0d", e.out_column, out_data.out_column);
          errors++;
        end
        if (out_data.out_row !== e.out_row) begin
          $error("out_row expected %0d actual %0d", e.out_row, out_data.out_row);
          errors++;
        end
        if (out_data.frame_last !== e.frame_last) begin
          $error("frame_last expected %0d actual %0d", e.frame_last, out_data.frame_last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_same_size();
    test_letterbox();
    test_size_clamp();
    test_random_frames();
    stop_input();
    wait (pending_pixels.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/nnrl_pkg.sv
rtl/core/nnrl_ram.sv
rtl/core/nnrl_div.sv
rtl/core/nearest_neighbour_resize_letterbox_top.sv
verif/nearest_neighbour_resize_letterbox_top_tb.sv
